// ===== hdl/tts_pkg.sv =====
// Shared types and constants for the two-way time-sync pending table.
`timescale 1ns / 1ps
`default_nettype none
package tts_pkg;

  localparam int CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WRAP_SPAN = 2'd0,
    CFG_DLY_EN    = 2'd1,
    CFG_EXP_DLY   = 2'd2,
    CFG_MARGIN    = 2'd3
  } cfg_idx_t;

  localparam logic CMD_REQUEST = 1'b0;
  localparam logic CMD_REPLY   = 1'b1;

  localparam logic [1:0] KIND_REQUEST   = 2'd0;
  localparam logic [1:0] KIND_MATCHED   = 2'd1;
  localparam logic [1:0] KIND_UNMATCHED = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_OVERWRITE = 2'd1;
  localparam logic [1:0] STAT_DELAY     = 2'd2;

  // Input beat fields.
  typedef struct packed {
    logic [31:0] t4;
    logic [31:0] t3;
    logic [31:0] t2;
    logic [31:0] t1;
    logic [7:0]  seq_no;
    logic [7:0]  handle;
    logic [15:0] peer_node;
    logic [7:0]  message_type;
    logic [7:0]  module_id;
  } in_item_t;

  // Result beat fields.
  typedef struct packed {
    logic signed [31:0] clock_offset;
    logic [1:0]  status;
    logic [7:0]  return_type;
    logic [7:0]  out_handle;
    logic        evicted;
    logic [15:0] out_peer;
    logic [7:0]  out_seq_no;
    logic [1:0]  result_kind;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // capture input beat
    logic scan;      // process one table slot
    logic commit;    // apply request / reply update
    logic arith;     // compute timestamp differences
    logic finish;    // form sum and difference for the offset
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic is_reply;
    logic scan_last;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== hdl/tts_datapath.sv =====
// Datapath of the pending table: entry registers, slot scan and offset maths.
`timescale 1ns / 1ps
`default_nettype none
module tts_datapath #(
  parameter int ENTRIES = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire tts_pkg::in_item_t   in_item,
  input  wire logic                in_cmd,
  input  wire tts_pkg::dp_cmd_t    cmd,
  output tts_pkg::dp_stat_t        stat,
  input  wire logic [31:0]         wrap_span,
  input  wire logic                dly_en,
  input  wire logic signed [31:0]  exp_dly,
  input  wire logic [30:0]         margin,
  output tts_pkg::out_item_t       result
);
  localparam int IdxW = $clog2(ENTRIES);
  localparam logic [2:0] FillAge = 3'(ENTRIES);

  logic [ENTRIES-1:0] occ_r;
  logic [7:0]  mod_r  [ENTRIES];
  logic [7:0]  mt_r   [ENTRIES];
  logic [15:0] peer_r [ENTRIES];
  logic [7:0]  hdl_r  [ENTRIES];
  logic [7:0]  seq_r  [ENTRIES];
  logic [2:0]  age_r  [ENTRIES];
  logic [7:0]  next_seq_r;

  tts_pkg::in_item_t it_r;
  logic              is_reply_r;
  logic [IdxW-1:0]   idx_r;
  // scan findings
  logic              dup_r, empty_f_r, hit_f_r;
  logic [IdxW-1:0]   dup_i_r, empty_i_r, old_i_r, hit_i_r;
  logic signed [32:0] a_r, b_r;
  logic signed [33:0] diff_r, sum_r;
  // offset stage runs the cycle after the sums are registered
  logic              fin_d_r;
  tts_pkg::out_item_t result_r, result_nxt;

  logic key_eq;
  assign key_eq = occ_r[idx_r] && mod_r[idx_r] == it_r.module_id &&
                  mt_r[idx_r] == it_r.message_type && peer_r[idx_r] == it_r.peer_node;

  assign stat.is_reply  = is_reply_r;
  assign stat.scan_last = (idx_r == IdxW'(ENTRIES - 1));
  assign result         = result_r;

  logic [31:0] t3w, t4w;
  logic [31:0] da, db;
  logic [2:0]  dec_age;
  logic [IdxW-1:0] slot;
  logic [2:0]  freed;
  logic signed [33:0] off, dly;
  logic signed [33:0] lo, hi;

  always_comb begin
    t4w = (it_r.t1 > it_r.t4) ? it_r.t4 + wrap_span : it_r.t4;
    t3w = (it_r.t2 > it_r.t3) ? it_r.t3 + wrap_span : it_r.t3;
    da = it_r.t2 - it_r.t1;
    db = t4w - t3w;
    dec_age = age_r[idx_r] - 3'd1;
    slot = dup_r ? dup_i_r : (empty_f_r ? empty_i_r : old_i_r);
    freed = age_r[hit_i_r];
    // truncation toward zero: add one before halving when negative
    off = (diff_r + $signed({33'd0, diff_r[33]})) >>> 1;
    dly = (sum_r + $signed({33'd0, sum_r[33]})) >>> 1;
    lo = 34'(exp_dly) - 34'($signed({1'b0, margin}));
    hi = 34'(exp_dly) + 34'($signed({1'b0, margin}));
  end

  always_comb begin
    result_nxt = result_r;
    if (cmd.commit) begin
      result_nxt = '0;
      if (!is_reply_r) begin
        result_nxt.result_kind = tts_pkg::KIND_REQUEST;
        result_nxt.out_seq_no  = next_seq_r;
        result_nxt.out_peer    = it_r.peer_node;
        if (!dup_r && !empty_f_r) begin
          result_nxt.evicted     = 1'b1;
          result_nxt.out_handle  = hdl_r[old_i_r];
          result_nxt.return_type = mt_r[old_i_r];
          result_nxt.status      = tts_pkg::STAT_OVERWRITE;
        end
      end else begin
        result_nxt.out_seq_no = it_r.seq_no;
        if (!hit_f_r) begin
          result_nxt.result_kind = tts_pkg::KIND_UNMATCHED;
        end else begin
          result_nxt.result_kind = tts_pkg::KIND_MATCHED;
          result_nxt.out_peer    = peer_r[hit_i_r];
          result_nxt.out_handle  = hdl_r[hit_i_r];
          result_nxt.return_type = mt_r[hit_i_r];
        end
      end
    end
    if (fin_d_r) begin
      if (dly_en && (dly < lo || dly > hi)) begin
        result_nxt.status       = tts_pkg::STAT_DELAY;
        result_nxt.clock_offset = '0;
      end else begin
        result_nxt.clock_offset = off[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r      <= '0;
      next_seq_r <= '0;
      fin_d_r    <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        seq_r[i] <= '0;
        age_r[i] <= '0;
      end
    end else begin
      fin_d_r  <= cmd.finish && is_reply_r && hit_f_r;
      result_r <= result_nxt;
      if (cmd.load) begin
        it_r       <= in_item;
        is_reply_r <= in_cmd;
        idx_r      <= '0;
        dup_r      <= 1'b0;
        empty_f_r  <= 1'b0;
        hit_f_r    <= 1'b0;
        dup_i_r    <= '0;
        empty_i_r  <= '0;
        old_i_r    <= '0;
        hit_i_r    <= '0;
      end
      if (cmd.scan) begin
        if (!stat.scan_last) idx_r <= idx_r + IdxW'(1);
        if (is_reply_r) begin
          if (!hit_f_r && occ_r[idx_r] && seq_r[idx_r] == it_r.seq_no) begin
            hit_f_r <= 1'b1;
            hit_i_r <= idx_r;
          end
        end else if (!dup_r && key_eq) begin
          dup_r   <= 1'b1;
          dup_i_r <= idx_r;
        end else if (!dup_r && !empty_f_r && !occ_r[idx_r]) begin
          empty_f_r <= 1'b1;
          empty_i_r <= idx_r;
        end else if (occ_r[idx_r]) begin
          age_r[idx_r] <= dec_age;
          if (dec_age == 3'd0) old_i_r <= idx_r;
        end
      end
      if (cmd.commit) begin
        if (!is_reply_r) begin
          occ_r[slot]  <= 1'b1;
          mod_r[slot]  <= it_r.module_id;
          mt_r[slot]   <= it_r.message_type;
          peer_r[slot] <= it_r.peer_node;
          hdl_r[slot]  <= it_r.handle;
          seq_r[slot]  <= next_seq_r;
          age_r[slot]  <= FillAge;
          next_seq_r   <= next_seq_r + 8'd1;
        end else if (hit_f_r) begin
          occ_r[hit_i_r] <= 1'b0;
          for (int i = 0; i < ENTRIES; i++)
            if (age_r[i] < freed) age_r[i] <= age_r[i] + 3'd1;
        end
      end
      if (cmd.arith) begin
        a_r <= 33'($signed(da));
        b_r <= 33'($signed(db));
      end
      if (cmd.finish) begin
        diff_r <= 34'(a_r) - 34'(b_r);
        sum_r  <= 34'(a_r) + 34'(b_r);
      end
    end
  end
endmodule
`default_nettype wire

// ===== hdl/tts_ctrl.sv =====
// Controller state machine sequencing the slot scan and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module tts_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output tts_pkg::dp_cmd_t      cmd,
  input  wire tts_pkg::dp_stat_t stat
);
  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_COMMIT, S_ARITH, S_FIN, S_OFF, S_OUT} state_t;
  state_t state_r;
  logic   out_tvalid_r;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;

  always_comb begin
    cmd        = '0;
    cmd.load   = in_tvalid && in_tready;
    cmd.scan   = (state_r == S_SCAN);
    cmd.commit = (state_r == S_COMMIT);
    cmd.arith  = (state_r == S_ARITH);
    cmd.finish = (state_r == S_FIN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE:   if (in_tvalid) state_r <= S_SCAN;
        S_SCAN:   if (stat.scan_last) state_r <= S_COMMIT;
        S_COMMIT: begin
          if (stat.is_reply) state_r <= S_ARITH;
          else begin
            state_r      <= S_OUT;
            out_tvalid_r <= 1'b1;
          end
        end
        S_ARITH:  state_r <= S_FIN;
        S_FIN:    state_r <= S_OFF;
        S_OFF: begin
          state_r      <= S_OUT;
          out_tvalid_r <= 1'b1;
        end
        S_OUT: if (out_tready) begin
          state_r      <= S_IDLE;
          out_tvalid_r <= 1'b0;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hdl/two_way_timesync_pending_table_top.sv =====
// Top level of the two-way time-sync pending table.
//   channel | dir | beat contents
//   in_     | in  | tuser: cmd; tdata: module_id..t4 (176 bits)
//   out_    | out | tdata: result_kind..clock_offset (77 bits, padded to 80)
//   cfg_    | in  | cfg_index (2b), cfg_data (32b), always ready
// The result is registered after the one-slot-a-cycle scan and the commit state for a
// request, and for a reply after the scan, commit, arith, finish and offset states.
// No new beat is accepted before the controller returns to idle.
// Synchronous active-low reset empties the table and zeroes the config and sequence registers.
// A result waits in its register while out_tready is low; no new beat is
// accepted until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module two_way_timesync_pending_table_top #(
  parameter int ENTRIES = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [175:0] in_tdata,  // module_id, message_type, peer_node, handle,
                                       // seq_no, t1, t2, t3, t4
  input  wire logic         in_tuser,  // cmd
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [79:0]       out_tdata, // result_kind, out_seq_no, out_peer, evicted,
                                       // out_handle, return_type, status, clock_offset, pad
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);
  tts_pkg::dp_cmd_t  cmd;
  tts_pkg::dp_stat_t stat;
  tts_pkg::out_item_t result;

  logic [31:0] wrap_span_r;
  logic        dly_en_r;
  logic [31:0] exp_dly_r;
  logic [30:0] margin_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_span_r <= '0;
      dly_en_r    <= 1'b0;
      exp_dly_r   <= '0;
      margin_r    <= '0;
    end else if (cfg_valid) begin
      unique case (tts_pkg::cfg_idx_t'(cfg_index))
        tts_pkg::CFG_WRAP_SPAN: wrap_span_r <= cfg_data;
        tts_pkg::CFG_DLY_EN:    dly_en_r    <= cfg_data[0];
        tts_pkg::CFG_EXP_DLY:   exp_dly_r   <= cfg_data;
        tts_pkg::CFG_MARGIN:    margin_r    <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  tts_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .cmd, .stat
  );

  tts_datapath #(.ENTRIES(ENTRIES)) u_dp (
    .clk, .rst_n,
    .in_item   (tts_pkg::in_item_t'(in_tdata)),
    .in_cmd    (in_tuser),
    .cmd, .stat,
    .wrap_span (wrap_span_r),
    .dly_en    (dly_en_r),
    .exp_dly   ($signed(exp_dly_r)),
    .margin    (margin_r),
    .result
  );

  assign out_tdata = {3'b0, result};
endmodule
`default_nettype wire

// ===== hdl/tts_checker.sv =====
// Port-level checker for the pending table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module tts_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [79:0] out_tdata
);
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while result pending");
  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed");
  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3) else $error("bad result kind");
  a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("back-to-back accept");
endmodule

bind two_way_timesync_pending_table_top tts_checker u_chk (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata
);
`default_nettype wire

// ===== verif/two_way_timesync_pending_table_top_tb.sv =====
// Self-checking testbench for the two-way time-sync pending table top level.
`timescale 1ns / 1ps
module two_way_timesync_pending_table_top_tb;

  localparam int NSLOT = 4;
  localparam int RANDOM_ITEMS = 1300;
  localparam int MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [175:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  two_way_timesync_pending_table_top #(.ENTRIES(NSLOT)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor copy of the table and registers
  logic        occ [NSLOT];
  logic [7:0]  tab_mod [NSLOT];
  logic [7:0]  tab_mt [NSLOT];
  logic [15:0] tab_peer [NSLOT];
  logic [7:0]  tab_handle [NSLOT];
  logic [7:0]  tab_seq [NSLOT];
  logic [2:0]  tab_age [NSLOT];
  logic [7:0]  seq_counter;
  logic [31:0] wrap_reg;
  logic        dly_en_reg;
  logic signed [31:0] exp_dly_reg;
  logic [30:0] margin_reg;

  tts_pkg::out_item_t pending_results[$];
  int mismatches = 0;
  int unexpected = 0;
  bit hold_off = 1'b0;   // long receiver hold-off, set by the stimulus
  bit stall_en = 1'b1;

  function automatic void table_reset();
    for (int i = 0; i < NSLOT; i++) begin
      occ[i] = 1'b0; tab_mod[i] = '0; tab_mt[i] = '0; tab_peer[i] = '0;
      tab_handle[i] = '0; tab_seq[i] = '0; tab_age[i] = '0;
    end
    seq_counter = '0;
    wrap_reg = '0; dly_en_reg = 1'b0; exp_dly_reg = '0; margin_reg = '0;
  endfunction

  function automatic void file_slot(int i, tts_pkg::in_item_t it);
    occ[i] = 1'b1; tab_mod[i] = it.module_id; tab_mt[i] = it.message_type;
    tab_peer[i] = it.peer_node; tab_handle[i] = it.handle; tab_seq[i] = seq_counter;
    tab_age[i] = 3'(NSLOT);
    seq_counter = seq_counter + 8'd1;
  endfunction

  // Works out the result for one beat and updates the predicted table.
  function automatic tts_pkg::out_item_t sync_result(logic cmd, tts_pkg::in_item_t it);
    tts_pkg::out_item_t r;
    bit dup;
    int empty, oldest, hit;
    logic [2:0] freed;
    logic [31:0] t3, t4;
    longint a, b, offs, dly;
    r = '0;
    if (cmd == tts_pkg::CMD_REQUEST) begin
      dup = 0; empty = -1; oldest = 0;
      for (int i = 0; i < NSLOT; i++) begin
        if (!dup && occ[i] && tab_mod[i] == it.module_id && tab_mt[i] == it.message_type
            && tab_peer[i] == it.peer_node) begin
          dup = 1;
          r.out_seq_no = seq_counter;
          file_slot(i, it);
        end else if (!dup && empty < 0 && !occ[i]) begin
          empty = i;
        end else if (occ[i]) begin
          tab_age[i] = tab_age[i] - 3'd1;
          if (tab_age[i] == 3'd0) oldest = i;
        end
      end
      r.result_kind = tts_pkg::KIND_REQUEST;
      r.out_peer = it.peer_node;
      if (!dup) begin
        r.out_seq_no = seq_counter;
        if (empty >= 0) begin
          file_slot(empty, it);
        end else begin
          r.evicted = 1'b1;
          r.out_handle = tab_handle[oldest];
          r.return_type = tab_mt[oldest];
          r.status = tts_pkg::STAT_OVERWRITE;
          file_slot(oldest, it);
        end
      end
      return r;
    end
    hit = -1;
    for (int i = 0; i < NSLOT; i++)
      if (hit < 0 && occ[i] && tab_seq[i] == it.seq_no) hit = i;
    r.out_seq_no = it.seq_no;
    if (hit < 0) begin
      r.result_kind = tts_pkg::KIND_UNMATCHED;
      return r;
    end
    occ[hit] = 1'b0;
    freed = tab_age[hit];
    for (int i = 0; i < NSLOT; i++)
      if (tab_age[i] < freed) tab_age[i] = tab_age[i] + 3'd1;
    r.result_kind = tts_pkg::KIND_MATCHED;
    r.out_peer = tab_peer[hit];
    r.out_handle = tab_handle[hit];
    r.return_type = tab_mt[hit];
    t3 = it.t3; t4 = it.t4;
    if (it.t1 > t4) t4 = t4 + wrap_reg;
    if (it.t2 > t3) t3 = t3 + wrap_reg;
    a = longint'($signed(it.t2 - it.t1));
    b = longint'($signed(t4 - t3));
    offs = (a - b) / 2;
    dly = (a + b) / 2;
    if (dly_en_reg && (dly < longint'(exp_dly_reg) - longint'(margin_reg) ||
                       dly > longint'(exp_dly_reg) + longint'(margin_reg))) begin
      r.status = tts_pkg::STAT_DELAY;
    end else begin
      r.clock_offset = offs[31:0];
    end
    return r;
  endfunction

  task automatic write_reg(tts_pkg::cfg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      tts_pkg::CFG_WRAP_SPAN: wrap_reg = val;
      tts_pkg::CFG_DLY_EN:    dly_en_reg = val[0];
      tts_pkg::CFG_EXP_DLY:   exp_dly_reg = val;
      default:                margin_reg = val[30:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drives one beat; a directed row may carry its own expectation.
  task automatic send_beat(logic cmd, tts_pkg::in_item_t it, bit has_exp,
                           tts_pkg::out_item_t known);
    tts_pkg::out_item_t p;
    in_tvalid <= 1'b1; in_tuser <= cmd; in_tdata <= it;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    p = sync_result(cmd, it);
    if (has_exp && p != known)
      $display("directed row disagrees with predictor: %h vs %h", known, p);
    pending_results.push_back(has_exp ? known : p);
    @(negedge clk);
  endtask

  task automatic idle_gap(int n);
    in_tvalid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0 && guard < 100000) begin
      @(negedge clk); guard++;
    end
    repeat (16) @(negedge clk);  // reply path latency with margin
  endtask

  function automatic tts_pkg::in_item_t rand_item();
    tts_pkg::in_item_t it;
    logic [191:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    it = raw[175:0];
    return it;
  endfunction

  // Receiver: own stall pattern plus the long hold-off
  initial begin
    int k;
    k = 0;
    forever begin
      @(negedge clk);
      k++;
      if (hold_off) out_tready <= 1'b0;
      else if (!stall_en) out_tready <= 1'b1;
      else out_tready <= ((k % 11) < 7) ? ($urandom_range(0, 3) != 0) : 1'b0;
    end
  end

  // Result checker, sampled at the rising edge
  always @(posedge clk) begin
    tts_pkg::out_item_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[76:0];
      if (pending_results.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= MAX_REPORTS)
          $display("result beat with nothing expected: %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got.result_kind !== want.result_kind || got.out_seq_no !== want.out_seq_no ||
            got.out_peer !== want.out_peer || got.evicted !== want.evicted ||
            got.out_handle !== want.out_handle || got.return_type !== want.return_type ||
            got.status !== want.status || got.clock_offset !== want.clock_offset) begin
          mismatches++;
          if (mismatches + unexpected <= MAX_REPORTS)
            $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  // Directed rows
  typedef struct {
    logic               cmd;
    tts_pkg::in_item_t  it;
    bit                 has_exp;
    tts_pkg::out_item_t known;
  } dir_row_t;

  dir_row_t rows[$];

  function automatic tts_pkg::in_item_t mk(logic [7:0] m, logic [7:0] t, logic [15:0] p,
                                           logic [7:0] h, logic [7:0] s, logic [31:0] a,
                                           logic [31:0] b, logic [31:0] c, logic [31:0] d);
    tts_pkg::in_item_t it;
    it.module_id = m; it.message_type = t; it.peer_node = p; it.handle = h;
    it.seq_no = s; it.t1 = a; it.t2 = b; it.t3 = c; it.t4 = d;
    return it;
  endfunction

  function automatic void add(logic c, tts_pkg::in_item_t it);
    rows.push_back('{c, it, 1'b0, '0});
  endfunction

  initial begin
    tts_pkg::out_item_t k;
    tts_pkg::in_item_t it;
    int n, live, slot;
    bit reqflag;
    table_reset();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // unmatched reply straight after reset: sequence echoed, rest zero
    k = '0; k.result_kind = tts_pkg::KIND_UNMATCHED; k.out_seq_no = 8'hFF;
    rows.push_back('{tts_pkg::CMD_REPLY,
                     mk(8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, '1, '1, '1, '1), 1'b1, k});
    // first request into an empty table gets sequence 0
    k = '0; k.result_kind = tts_pkg::KIND_REQUEST; k.out_peer = 16'hFFFF;
    rows.push_back('{tts_pkg::CMD_REQUEST,
                     mk(8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 0, 0, 0, 0, 0), 1'b1, k});
    add(tts_pkg::CMD_REQUEST, mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
    add(tts_pkg::CMD_REQUEST, mk(8'hFF, 8'hFF, 16'hFFFF, 8'h11, 0, 0, 0, 0, 0)); // duplicate key
    add(tts_pkg::CMD_REQUEST, mk(1, 2, 3, 4, 0, 0, 0, 0, 0));
    add(tts_pkg::CMD_REQUEST, mk(5, 6, 7, 8, 0, 0, 0, 0, 0));      // table full now
    add(tts_pkg::CMD_REQUEST, mk(9, 10, 11, 12, 0, 0, 0, 0, 0));   // eviction
    add(tts_pkg::CMD_REQUEST, mk(13, 14, 15, 16, 0, 0, 0, 0, 0));
    add(tts_pkg::CMD_REPLY, mk(0, 0, 0, 0, 8'd4, 32'd100, 32'd150, 32'd160, 32'd120));
    add(tts_pkg::CMD_REPLY, mk(0, 0, 0, 0, 8'd5, '1, 32'd5, 32'd3, 32'd7));       // both wrap
    add(tts_pkg::CMD_REPLY, mk(0, 0, 0, 0, 8'd4, 0, 0, 0, 0));                    // already freed
    add(tts_pkg::CMD_REPLY, mk(0, 0, 0, 0, 8'd6, 32'h8000_0000, 0, '1, 32'h7FFF_FFFF));
    add(tts_pkg::CMD_REPLY, mk(0, 0, 0, 0, 8'd7, 0, 32'h7FFF_FFFF, 0, 32'h8000_0000));
    foreach (rows[i]) send_beat(rows[i].cmd, rows[i].it, rows[i].has_exp, rows[i].known);
    drain();

    // random phases across register settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(tts_pkg::CFG_WRAP_SPAN, '1); write_reg(tts_pkg::CFG_DLY_EN, 1);
                 write_reg(tts_pkg::CFG_EXP_DLY, 32'h8000_0000);
                 write_reg(tts_pkg::CFG_MARGIN, 32'h7FFF_FFFF); end
        1: begin write_reg(tts_pkg::CFG_WRAP_SPAN, 32'h1000);
                 write_reg(tts_pkg::CFG_EXP_DLY, 32'd50);
                 write_reg(tts_pkg::CFG_MARGIN, 32'd40); end
        2: begin write_reg(tts_pkg::CFG_EXP_DLY, 32'h7FFF_FFFF);
                 write_reg(tts_pkg::CFG_MARGIN, 0); end
        3: begin write_reg(tts_pkg::CFG_DLY_EN, 0); write_reg(tts_pkg::CFG_WRAP_SPAN, 0); end
        4: begin write_reg(tts_pkg::CFG_DLY_EN, 1); write_reg(tts_pkg::CFG_EXP_DLY, $urandom());
                 write_reg(tts_pkg::CFG_MARGIN, $urandom());
                 write_reg(tts_pkg::CFG_WRAP_SPAN, $urandom()); end
        default: begin write_reg(tts_pkg::CFG_EXP_DLY, 0);
                 write_reg(tts_pkg::CFG_MARGIN, 32'd1000); end
      endcase
      stall_en = (ph != 3);
      for (n = 0; n < RANDOM_ITEMS / 6; n++) begin
        if (ph == 2 && n == 20) begin
          fork
            begin hold_off = 1'b1; repeat (300) @(negedge clk); hold_off = 1'b0; end
          join_none
        end
        it = rand_item();
        // mostly small key space so duplicates, evictions and matches happen
        if ($urandom_range(0, 9) != 0) begin
          it.module_id = $urandom_range(0, 2); it.message_type = $urandom_range(0, 1);
          it.peer_node = $urandom_range(0, 2);
        end
        reqflag = $urandom_range(0, 1);
        if (!reqflag && $urandom_range(0, 5) != 0) begin
          live = 0;
          for (int i = 0; i < NSLOT; i++) if (occ[i]) live++;
          if (live > 0) begin
            slot = $urandom_range(0, NSLOT - 1);
            while (!occ[slot]) slot = (slot + 1) % NSLOT;
            it.seq_no = tab_seq[slot];
          end
          if ($urandom_range(0, 1)) begin
            it.t2 = it.t1 + $urandom_range(0, 2000) - 1000;
            it.t3 = it.t2 + $urandom_range(0, 500);
            it.t4 = it.t1 + $urandom_range(0, 3000);
          end
        end
        send_beat(reqflag ? tts_pkg::CMD_REQUEST : tts_pkg::CMD_REPLY, it, 1'b0, '0);
        if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 12));
      end
      drain();
    end
    stall_en = 1'b1;

    if (mismatches == 0 && unexpected == 0 && pending_results.size() == 0)
      $display("two_way_timesync_pending_table_top_tb: done, clean");
    else
      $display("two_way_timesync_pending_table_top_tb: done, errors");
    $finish;
  end

  // Hard limit on run time
  initial begin
    #4_000_000;
    $display("two_way_timesync_pending_table_top_tb: done, errors");
    $finish;
  end

endmodule
